@@ hw/rtl/msprd_pkg.sv @@
// Shared types and constants for the MSPv2 reply deframer.
`default_nettype none

package msprd_pkg;

  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_X      = 8'h58;
  localparam logic [7:0] CHAR_GT     = 8'h3E;
  localparam logic [7:0] CHAR_BANG   = 8'h21;

  localparam logic [15:0] CAP_RESET = 16'd512;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_DONE = 2'd1,
    KIND_OVER = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data_byte;
    logic [15:0] command;
    logic [15:0] payload_length;
  } result_t;

  typedef struct packed {
    logic main_valid;
    logic skid_valid;
  } buf_status_t;

endpackage

`default_nettype wire

@@ hw/rtl/mspv2_reply_deframer.sv @@
// MSPv2 reply deframer: finds reply frames in a byte stream and emits payload and status beats.
//
// Input channel: one received byte per beat on rx_byte, taken when in_valid is high and
// in_stall is low. Output channel: one result per beat (kind, data_byte, command,
// payload_length), taken when out_valid is high and out_stall is low. A beat of kind 0
// carries one payload byte, kind 1 marks the end of a frame on its checksum byte, and
// kind 2 reports a declared length above payload_cap, after which the hunt restarts.
// Header, flag and command bytes, and the length bytes of a frame within the cap, produce no output beat.
// Throughput is one input beat per clock while in_stall is low; the parser state updates in
// the same cycle the byte is taken, and a result is registered into the output buffer.
// A two-entry output buffer lets input beats keep flowing while a result waits; in_stall
// rises only when both entries hold results the receiver has not yet taken.
// payload_cap is written through cfg_we / cfg_data and resets to 512.
// Synchronous reset returns the parser to hunting for the start character, clears the
// command and length registers and empties the output buffer.
`default_nettype none

module mspv2_reply_deframer
  import msprd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  rx_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       kind,
  output logic [7:0]       data_byte,
  output logic [15:0]      command,
  output logic [15:0]      payload_length
);

  logic        take;
  logic        res_valid;
  logic        buf_full;
  result_t     res;
  result_t     out_res;
  buf_status_t buf_status;

  assign in_stall = buf_full;
  assign take     = in_valid & ~buf_full;

  msprd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .take      (take),
    .rx_byte   (rx_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  msprd_outbuf u_outbuf (
    .clk        (clk),
    .rst        (rst),
    .push_valid (res_valid),
    .push_res   (res),
    .full       (buf_full),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_res    (out_res),
    .status     (buf_status)
  );

  assign kind           = out_res.kind;
  assign data_byte      = out_res.data_byte;
  assign command        = out_res.command;
  assign payload_length = out_res.payload_length;

  a_skid_needs_main : assert property (@(posedge clk) disable iff (rst)
    buf_status.skid_valid |-> buf_status.main_valid)
    else $error("skid entry held while main entry empty");

  a_status_data_zero : assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != KIND_DATA |-> data_byte == 8'd0)
    else $error("status beat carries nonzero data byte");

  a_skid_drains : assert property (@(posedge clk) disable iff (rst)
    buf_status.skid_valid && !out_stall |=> buf_status.main_valid && !buf_status.skid_valid)
    else $error("skid entry did not move to main entry");

  a_reset_empty : assert property (@(posedge clk)
    $past(rst) |-> !out_valid && !in_stall)
    else $error("output buffer not empty after reset");

endmodule

`default_nettype wire

@@ hw/rtl/msprd_parser.sv @@
// Frame parser: header hunt, command and length assembly, payload counting.
`default_nettype none

module msprd_parser
  import msprd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_data,
  input  wire logic        take,
  input  wire logic [7:0]  rx_byte,
  output logic             res_valid,
  output result_t          res
);

  typedef enum logic [9:0] {
    PH_HUNT   = 10'b00_0000_0001,
    PH_X      = 10'b00_0000_0010,
    PH_DIR    = 10'b00_0000_0100,
    PH_FLAG   = 10'b00_0000_1000,
    PH_CMD_LO = 10'b00_0001_0000,
    PH_CMD_HI = 10'b00_0010_0000,
    PH_LEN_LO = 10'b00_0100_0000,
    PH_LEN_HI = 10'b00_1000_0000,
    PH_DATA   = 10'b01_0000_0000,
    PH_CRC    = 10'b10_0000_0000
  } phase_t;

  phase_t      phase, phase_next;
  logic [15:0] payload_cap;
  logic [15:0] cmd_reg, cmd_reg_next;
  logic [15:0] len_reg, len_reg_next;
  logic [15:0] byte_count, byte_count_next;
  logic [15:0] count_inc;
  logic        emit;
  kind_t       emit_kind;
  logic [7:0]  emit_data;

  assign count_inc = byte_count + 16'd1;

  always_comb begin
    phase_next      = phase;
    cmd_reg_next    = cmd_reg;
    len_reg_next    = len_reg;
    byte_count_next = byte_count;
    emit            = 1'b0;
    emit_kind       = KIND_DATA;
    emit_data       = 8'd0;
    case (phase)
      PH_X: begin
        phase_next = (rx_byte == CHAR_X) ? PH_DIR : PH_HUNT;
      end
      PH_DIR: begin
        phase_next = (rx_byte == CHAR_GT || rx_byte == CHAR_BANG) ? PH_FLAG : PH_HUNT;
      end
      PH_FLAG: begin
        phase_next = PH_CMD_LO;
      end
      PH_CMD_LO: begin
        cmd_reg_next = {8'd0, rx_byte};
        phase_next   = PH_CMD_HI;
      end
      PH_CMD_HI: begin
        cmd_reg_next = {rx_byte, cmd_reg[7:0]};
        phase_next   = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        len_reg_next = {8'd0, rx_byte};
        phase_next   = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        len_reg_next    = {rx_byte, len_reg[7:0]};
        byte_count_next = 16'd0;
        if (len_reg_next > payload_cap) begin
          phase_next = PH_HUNT;
          emit       = 1'b1;
          emit_kind  = KIND_OVER;
        end else begin
          phase_next = (len_reg_next != 16'd0) ? PH_DATA : PH_CRC;
        end
      end
      PH_DATA: begin
        byte_count_next = count_inc;
        phase_next      = (count_inc >= len_reg) ? PH_CRC : PH_DATA;
        emit            = 1'b1;
        emit_kind       = KIND_DATA;
        emit_data       = rx_byte;
      end
      PH_CRC: begin
        // The checksum byte is swallowed without being checked.
        phase_next = PH_HUNT;
        emit       = 1'b1;
        emit_kind  = KIND_DONE;
      end
      default: begin
        phase_next = (rx_byte == CHAR_DOLLAR) ? PH_X : PH_HUNT;
      end
    endcase
  end

  assign res_valid          = take & emit;
  assign res.kind           = emit_kind;
  assign res.data_byte      = emit_data;
  assign res.command        = cmd_reg_next;
  assign res.payload_length = len_reg_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HUNT;
      payload_cap <= CAP_RESET;
      cmd_reg     <= 16'd0;
      len_reg     <= 16'd0;
      byte_count  <= 16'd0;
    end else begin
      if (cfg_we) begin
        payload_cap <= cfg_data;
      end
      if (take) begin
        phase      <= phase_next;
        cmd_reg    <= cmd_reg_next;
        len_reg    <= len_reg_next;
        byte_count <= byte_count_next;
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/msprd_outbuf.sv @@
// Result register with a skid stage so the input side waits on the output stall only when both are full.
`default_nettype none

module msprd_outbuf
  import msprd_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push_valid,
  input  wire result_t push_res,
  output logic         full,
  output logic         out_valid,
  input  wire logic    out_stall,
  output result_t      out_res,
  output buf_status_t  status
);

  logic    main_valid;
  logic    skid_valid;
  result_t main_res;
  result_t skid_res;
  logic    pop;

  assign pop       = main_valid & ~out_stall;
  assign full      = skid_valid;
  assign out_valid = main_valid;
  assign out_res   = main_res;

  assign status.main_valid = main_valid;
  assign status.skid_valid = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        main_valid <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (push_valid) begin
      if (!main_valid || pop) begin
        main_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      main_valid <= 1'b0;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        main_res <= skid_res;
      end
    end else if (push_valid) begin
      if (!main_valid || pop) begin
        main_res <= push_res;
      end else begin
        skid_res <= push_res;
      end
    end
  end

endmodule

`default_nettype wire
